[sv/mfif_pkg.sv]
`default_nettype none

package mfif_pkg;

  // Control from the sequencer to the store/count datapath.
  typedef struct packed {
    logic wr_en;        // write the incoming element
    logic capture;      // latch read data as the candidate, clear the count
    logic scan;         // a compare read is issued this cycle
  } mfif_ctrl_t;

endpackage

`default_nettype wire

[sv/mfif_counter.sv]
`default_nettype none

module mfif_counter
  import mfif_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mfif_ctrl_t                   ctrl,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr,
  input  wire logic [WIDTH-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr,
  output logic      [$clog2(DEPTH+1)-1:0]   count_total
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data;
  logic [WIDTH-1:0] cand;
  logic [CW-1:0]    cnt;
  logic             cmp_valid;
  logic             match;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // rd_data lines up with cmp_valid in the cycle after the scan read
  assign match       = cmp_valid && (rd_data == cand);
  assign count_total = cnt + CW'(match);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= ctrl.scan;
    end
    if (ctrl.capture) begin
      cand <= rd_data;
      cnt  <= '0;
    end else begin
      cnt  <= count_total;
    end
  end

endmodule

`default_nettype wire

[sv/mode_first_index_finder.sv]
`default_nettype none
// Mode search over a set of elements.
// Input channel (in_valid / in_stall): one element per request, element_value
// plus last_element. The request with last_element set closes the set.
// Up to MAX_ELEMENTS elements are stored; later ones are dropped and the
// result's overflowed bit is set.
// Output channel (out_valid / out_stall): one request per set carrying the
// index of the first occurrence of the most frequent element, its count and
// the overflow flag.
// While loading, in_stall is low and every valid request is taken. After the
// closing request the block holds in_stall high and compares every stored
// element against all n stored elements through the single read port of the
// element memory. A finished result sits in the output register; the block
// reloads while it waits, and only holds in the final step if the previous
// result is still stalled there.
// Reset (rst, synchronous) empties the set and drops any pending result;
// memory contents are not cleared, only entries written in the current set
// are ever read.
module mode_first_index_finder
  import mfif_pkg::*;
#(
  parameter int MAX_ELEMENTS  = 256,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] element_value,
  input  wire logic        last_element,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       mode_index,
  output logic [8:0]       mode_count,
  output logic             overflowed
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MAX_FILL = CW'(MAX_ELEMENTS);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_CAPT  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_TAIL  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] fill;
  logic          ovf;
  logic [CW-1:0] i_idx;
  logic [CW-1:0] j_idx;
  logic [CW-1:0] best_cnt;
  logic [AW-1:0] best_idx;

  logic [63:0]              elem_wide;
  logic [ELEMENT_WIDTH-1:0] elem_in;
  logic                     accept;
  logic                     room;
  logic                     last_j;
  logic                     last_i;
  logic                     out_free;
  logic [CW-1:0]            count_total;
  mfif_ctrl_t               ctrl;
  logic [AW-1:0]            raddr;

  assign elem_wide = {32'd0, element_value};
  assign elem_in   = elem_wide[ELEMENT_WIDTH-1:0];

  assign in_stall = (state != ST_LOAD);
  assign accept   = in_valid && !in_stall;
  assign room     = (fill < MAX_FILL);
  assign last_j   = (j_idx == fill - CW'(1));
  assign last_i   = (i_idx == fill - CW'(1));
  assign out_free = !out_valid || !out_stall;

  assign ctrl.wr_en   = accept && room;
  assign ctrl.capture = (state == ST_CAPT);
  assign ctrl.scan    = (state == ST_SCAN);
  assign raddr        = (state == ST_SCAN) ? j_idx[AW-1:0] : i_idx[AW-1:0];

  mfif_counter #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (ELEMENT_WIDTH)
  ) u_counter (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .waddr       (fill[AW-1:0]),
    .wdata       (elem_in),
    .raddr       (raddr),
    .count_total (count_total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      fill      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // in ST_DONE the issue path below owns out_valid
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (room) begin
              fill <= fill + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (last_element) begin
              state    <= ST_FETCH;
              i_idx    <= '0;
              best_cnt <= '0;
              best_idx <= '0;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_CAPT;
        end
        ST_CAPT: begin
          j_idx <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          j_idx <= j_idx + CW'(1);
          if (last_j) begin
            state <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          // strictly greater: earliest index wins ties
          if (count_total > best_cnt) begin
            best_cnt <= count_total;
            best_idx <= i_idx[AW-1:0];
          end
          if (last_i) begin
            state <= ST_DONE;
          end else begin
            i_idx <= i_idx + CW'(1);
            state <= ST_FETCH;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            mode_index <= 8'(best_idx);
            mode_count <= 9'(best_cnt);
            overflowed <= ovf;
            out_valid  <= 1'b1;
            fill       <= '0;
            ovf        <= 1'b0;
            state      <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= MAX_FILL)
    else $error("fill count beyond store depth");

  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD) |-> (best_cnt <= fill))
    else $error("best count exceeds set size");

  a_close_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && last_element) |=> (state == ST_FETCH && fill != '0))
    else $error("closing request did not start the search");

  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (out_valid && fill == '0 && !ovf))
    else $error("result issue did not reset the set");

endmodule

`default_nettype wire
